/* rtl/css_pkg.sv */
`default_nettype none

package css_pkg;

    localparam int LEVEL_W    = 20;
    localparam int STEP_W     = 19;
    localparam int CYC_W      = 8;
    localparam int PER_W      = 16;
    localparam int TOL_W      = 10;
    localparam int CNT_W      = 32;
    localparam int SAMPLE_W   = 12;
    localparam int DAC_W      = 19;
    localparam int WIDE_W     = 22;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_BEGIN_LEVEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_VERTEX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_VERTEX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_TARGET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOL     = 3'd6;

    localparam logic [1:0] TGT_FIRST  = 2'd0;
    localparam logic [1:0] TGT_SECOND = 2'd1;
    localparam logic [1:0] TGT_BEGIN  = 2'd2;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam logic signed [WIDE_W-1:0] DAC_OFFSET = 22'sd200000;

    localparam logic signed [LEVEL_W-1:0] RST_BEGIN_LEVEL   = 20'sd0;
    localparam logic signed [LEVEL_W-1:0] RST_FIRST_VERTEX  = 20'sd50000;
    localparam logic signed [LEVEL_W-1:0] RST_SECOND_VERTEX = -20'sd50000;
    localparam logic [CYC_W-1:0]          RST_CYCLE_TARGET  = 8'd1;
    localparam logic [STEP_W-1:0]         RST_STEP_SIZE     = 19'd1000;
    localparam logic [PER_W-1:0]          RST_PERIOD_MS     = 16'd100;
    localparam logic [TOL_W-1:0]          RST_MATCH_TOL     = 10'd1;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] begin_level;
        logic signed [LEVEL_W-1:0] first_vertex;
        logic signed [LEVEL_W-1:0] second_vertex;
        logic [CYC_W-1:0]          cycle_target;
        logic [STEP_W-1:0]         step_size;
        logic [PER_W-1:0]          period_ms;
        logic [TOL_W-1:0]          match_tolerance;
    } cfg_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic [1:0]                target_sel;
        logic [CYC_W-1:0]          cycles_done;
        logic [CNT_W-1:0]          point_count;
        logic [CNT_W-1:0]          elapsed_ms;
        logic                      running;
    } sweep_state_t;

    typedef struct packed {
        logic [CNT_W-1:0]          point_index;
        logic [CNT_W-1:0]          time_ms;
        logic [SAMPLE_W-1:0]       ref_out;
        logic [SAMPLE_W-1:0]       tia_out;
        logic signed [LEVEL_W-1:0] cell_setpoint;
        logic [DAC_W-1:0]          dac_level;
        logic                      last;
    } point_t;

endpackage

`default_nettype wire

/* rtl/css_step.sv */
`default_nettype none

module css_step
(
    input  var css_pkg::cfg_t                  cfg,
    input  var css_pkg::sweep_state_t          state,
    input  wire                                req_type,
    input  wire [css_pkg::SAMPLE_W-1:0]        ref_sample,
    input  wire [css_pkg::SAMPLE_W-1:0]        tia_sample,
    output css_pkg::sweep_state_t              state_next,
    output css_pkg::point_t                    point,
    output logic                               emit
);
    import css_pkg::*;

    logic signed [WIDE_W-1:0]  level_w;
    logic signed [WIDE_W-1:0]  target_w;
    logic signed [WIDE_W-1:0]  step_w;
    logic signed [WIDE_W-1:0]  moved_w;
    logic signed [WIDE_W-1:0]  diff_w;
    logic signed [WIDE_W-1:0]  diff_abs;
    logic signed [WIDE_W-1:0]  tol_w;
    logic signed [WIDE_W-1:0]  half_w;
    logic signed [WIDE_W-1:0]  dac_w;
    logic signed [LEVEL_W-1:0] new_level;
    logic [CYC_W-1:0]          cycles_inc;
    logic                      last;

    always_comb
    begin
        level_w = WIDE_W'(state.level);
        unique case (state.target_sel)
            TGT_SECOND: target_w = WIDE_W'(cfg.second_vertex);
            TGT_BEGIN:  target_w = WIDE_W'(cfg.begin_level);
            default:    target_w = WIDE_W'(cfg.first_vertex);
        endcase

        step_w = (cfg.step_size == '0) ? WIDE_W'(1)
               : $signed({{(WIDE_W-STEP_W){1'b0}}, cfg.step_size});
        tol_w  = (cfg.match_tolerance == '0) ? WIDE_W'(1)
               : $signed({{(WIDE_W-TOL_W){1'b0}}, cfg.match_tolerance});

        moved_w = level_w;
        if (target_w < level_w)
        begin
            moved_w = level_w - step_w;
            if (moved_w < target_w)
                moved_w = target_w;
        end
        else if (target_w > level_w)
        begin
            moved_w = level_w + step_w;
            if (moved_w > target_w)
                moved_w = target_w;
        end

        diff_w   = moved_w - target_w;
        diff_abs = (diff_w < 0) ? -diff_w : diff_w;
        cycles_inc = state.cycles_done + CYC_W'(1);

        state_next = state;
        last       = 1'b0;
        emit       = 1'b0;

        if (req_type == REQ_START)
        begin
            emit                   = 1'b1;
            state_next.level       = cfg.begin_level;
            state_next.target_sel  = TGT_FIRST;
            state_next.cycles_done = '0;
            state_next.point_count = '0;
            state_next.elapsed_ms  = '0;
            state_next.running     = (cfg.cycle_target != '0);
            last                   = (cfg.cycle_target == '0);
        end
        else if (state.running)
        begin
            emit             = 1'b1;
            state_next.level = moved_w[LEVEL_W-1:0];
            if (diff_abs < tol_w)
            begin
                unique case (state.target_sel)
                    TGT_SECOND: state_next.target_sel = TGT_BEGIN;
                    TGT_BEGIN:
                    begin
                        state_next.target_sel  = TGT_FIRST;
                        state_next.cycles_done = cycles_inc;
                        if (cycles_inc == cfg.cycle_target)
                        begin
                            last               = 1'b1;
                            state_next.running = 1'b0;
                        end
                    end
                    default:    state_next.target_sel = TGT_SECOND;
                endcase
            end
        end

        new_level = state_next.level;
        // arithmetic shift gives floor of level / 2
        half_w = WIDE_W'(new_level) >>> 1;
        dac_w  = half_w + DAC_OFFSET;

        point.point_index   = state_next.point_count + CNT_W'(1);
        point.time_ms       = state_next.elapsed_ms;
        point.ref_out       = ref_sample;
        point.tia_out       = tia_sample;
        point.cell_setpoint = new_level;
        point.dac_level     = (dac_w < 0) ? '0 : dac_w[DAC_W-1:0];
        point.last          = last;

        if (emit)
        begin
            state_next.point_count = state_next.point_count + CNT_W'(1);
            state_next.elapsed_ms  = state_next.elapsed_ms + CNT_W'(cfg.period_ms);
        end
    end

endmodule

`default_nettype wire

/* rtl/cyclic_sweep_sequencer_core.sv */
`default_nettype none

// Triangle sweep sequencer for cyclic voltammetry. A start word (tuser 0)
// loads the begin potential and emits point 1; each tick word (tuser 1)
// steps the setpoint toward the current target (a vertex or the begin
// potential) and emits one point; the final point of the last cycle
// carries tlast. Ticks while idle are swallowed. One word is taken per
// clock unless the master side stalls; a word passes the input register,
// then the output register. The combinational step/clamp/compare loop
// that updates the sweep state sets the rate. Config writes are taken at
// any time and must only be issued while no words are in flight.
module cyclic_sweep_sequencer_core
#(
    parameter int ADC_BITS = 12
)
(
    input  wire                                clk,
    input  wire                                rst_n,

    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // [11:0] ref_sample, [23:12] tia_sample
    input  wire [23:0]                         s_axis_tdata,
    // [0] req_type
    input  wire                                s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // [31:0] point_index, [63:32] time_ms, [75:64] ref_out, [87:76] tia_out,
    // [107:88] cell_setpoint, [126:108] dac_level, [127] zero
    output logic [127:0]                       m_axis_tdata,
    output logic                               m_axis_tlast,

    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [css_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [css_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import css_pkg::*;

    logic [SAMPLE_W-1:0]  adc_mask;
    cfg_t                 cfg_reg;
    sweep_state_t         state_reg;
    sweep_state_t         state_next;
    point_t               point_next;
    point_t               out_reg;
    logic                 out_valid_reg;
    logic                 in_valid_reg;
    logic                 in_type_reg;
    logic [SAMPLE_W-1:0]  in_ref_reg;
    logic [SAMPLE_W-1:0]  in_tia_reg;
    logic                 emit;
    logic                 advance;

    always_comb
    begin
        for (int i = 0; i < SAMPLE_W; i++)
            adc_mask[i] = (i < ADC_BITS);
    end

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.begin_level     <= RST_BEGIN_LEVEL;
            cfg_reg.first_vertex    <= RST_FIRST_VERTEX;
            cfg_reg.second_vertex   <= RST_SECOND_VERTEX;
            cfg_reg.cycle_target    <= RST_CYCLE_TARGET;
            cfg_reg.step_size       <= RST_STEP_SIZE;
            cfg_reg.period_ms       <= RST_PERIOD_MS;
            cfg_reg.match_tolerance <= RST_MATCH_TOL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BEGIN_LEVEL:   cfg_reg.begin_level     <= cfg_data;
                REG_FIRST_VERTEX:  cfg_reg.first_vertex    <= cfg_data;
                REG_SECOND_VERTEX: cfg_reg.second_vertex   <= cfg_data;
                REG_CYCLE_TARGET:  cfg_reg.cycle_target    <= cfg_data[CYC_W-1:0];
                REG_STEP_SIZE:     cfg_reg.step_size       <= cfg_data[STEP_W-1:0];
                REG_PERIOD_MS:     cfg_reg.period_ms       <= cfg_data[PER_W-1:0];
                REG_MATCH_TOL:     cfg_reg.match_tolerance <= cfg_data[TOL_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tvalid && s_axis_tready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_type_reg <= s_axis_tuser;
            in_ref_reg  <= s_axis_tdata[11:0] & adc_mask;
            in_tia_reg  <= s_axis_tdata[23:12] & adc_mask;
        end
    end

    css_step u_step
    (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .req_type   (in_type_reg),
        .ref_sample (in_ref_reg),
        .tia_sample (in_tia_reg),
        .state_next (state_next),
        .point      (point_next),
        .emit       (emit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            out_reg <= point_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {1'b0, out_reg.dac_level, out_reg.cell_setpoint,
                            out_reg.tia_out, out_reg.ref_out,
                            out_reg.time_ms, out_reg.point_index};

    // sweep only stops on the point that closes the final cycle
    a_stop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(state_reg.running) |-> (out_valid_reg && out_reg.last))
        else $error("sweep stopped without a last point");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg)
        else $error("input stalled with empty input register");

    a_out_from_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("point produced without a pending word");

endmodule

`default_nettype wire
